FILE: hdl/zdt_pkg.sv
package zdt_pkg;

  localparam int COORD_BITS = 12;
  localparam int TIME_BITS  = 32;
  localparam int TOTAL_BITS = 32;
  localparam int CFG_DATA_BITS = (TIME_BITS > COORD_BITS) ? TIME_BITS : COORD_BITS;
  localparam int CFG_IDX_BITS  = 3;

  // register indexes of the configuration port
  localparam logic [CFG_IDX_BITS-1:0] CFG_ZONE_LEFT   = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_ZONE_TOP    = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_ZONE_WIDTH  = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] CFG_ZONE_HEIGHT = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] CFG_DWELL_LIMIT = 3'd4;

  typedef struct packed {
    logic [COORD_BITS-1:0] left;
    logic [COORD_BITS-1:0] top;
    logic [COORD_BITS-1:0] width;
    logic [COORD_BITS-1:0] height;
    logic [TIME_BITS-1:0]  dwell;
  } cfg_t;

  // one item after the zone test
  typedef struct packed {
    logic                 hit;
    logic                 last;
    logic [TIME_BITS-1:0] now;
  } item_t;

  typedef struct packed {
    logic                  trigger;
    logic [TOTAL_BITS-1:0] total;
    logic                  active;
    logic                  counted;
  } result_t;

endpackage

FILE: hdl/zdt_cfg.sv
module zdt_cfg (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_we_i,
  input  logic [zdt_pkg::CFG_IDX_BITS-1:0]      cfg_idx_i,
  input  logic [zdt_pkg::CFG_DATA_BITS-1:0]     cfg_wdata_i,
  output zdt_pkg::cfg_t                         cfg_o
);
  import zdt_pkg::*;

  cfg_t cfg_q;
  cfg_t cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_ZONE_LEFT:   cfg_d.left   = cfg_wdata_i[COORD_BITS-1:0];
        CFG_ZONE_TOP:    cfg_d.top    = cfg_wdata_i[COORD_BITS-1:0];
        CFG_ZONE_WIDTH:  cfg_d.width  = cfg_wdata_i[COORD_BITS-1:0];
        CFG_ZONE_HEIGHT: cfg_d.height = cfg_wdata_i[COORD_BITS-1:0];
        CFG_DWELL_LIMIT: cfg_d.dwell  = cfg_wdata_i[TIME_BITS-1:0];
        default:         cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

FILE: hdl/zdt_hit.sv
module zdt_hit (
  input  zdt_pkg::cfg_t                     cfg_i,
  input  logic [zdt_pkg::COORD_BITS-1:0]    point_x_i,
  input  logic [zdt_pkg::COORD_BITS-1:0]    point_y_i,
  input  logic                              point_valid_i,
  output logic                              hit_o
);
  import zdt_pkg::*;

  logic [COORD_BITS:0] right;
  logic [COORD_BITS:0] bottom;

  // bounds one bit wider so nothing wraps
  assign right  = {1'b0, cfg_i.left} + {1'b0, cfg_i.width};
  assign bottom = {1'b0, cfg_i.top} + {1'b0, cfg_i.height};

  assign hit_o = point_valid_i
              && (point_x_i > cfg_i.left) && ({1'b0, point_x_i} < right)
              && (point_y_i > cfg_i.top)  && ({1'b0, point_y_i} < bottom);

endmodule

FILE: hdl/zdt_zone.sv
module zdt_zone (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  zdt_pkg::cfg_t        cfg_i,
  input  logic                 item_valid_i,
  input  zdt_pkg::item_t       item_i,
  output logic                 item_ready_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output zdt_pkg::result_t     result_o
);
  import zdt_pkg::*;

  logic                  seen_q, seen_d;
  logic                  active_q, active_d;
  logic                  counted_q, counted_d;
  logic [TIME_BITS-1:0]  stamp_q, stamp_d;
  logic [TOTAL_BITS-1:0] total_q, total_d;
  logic                  out_valid_q, out_valid_d;
  result_t               result_q, result_d;

  logic                  out_ready;
  logic                  take;
  logic                  found;
  logic                  fired;
  logic [TIME_BITS-1:0]  elapsed;

  assign out_ready    = !out_valid_q || !out_stall_i;
  assign item_ready_o = !item_i.last || out_ready;
  assign take         = item_valid_i && item_ready_o;
  assign found        = seen_q || item_i.hit;
  assign elapsed      = item_i.now - stamp_q;

  always_comb begin
    seen_d    = seen_q;
    active_d  = active_q;
    counted_d = counted_q;
    stamp_d   = stamp_q;
    total_d   = total_q;
    fired     = 1'b0;
    if (take) begin
      if (!item_i.last) begin
        seen_d = found;
      end else begin
        seen_d = 1'b0;
        if (active_q) begin
          if (!found) begin
            active_d  = 1'b0;
            counted_d = 1'b0;
            stamp_d   = '0;
          end else if (!counted_q && (elapsed > cfg_i.dwell)) begin
            total_d   = total_q + TOTAL_BITS'(1);
            counted_d = 1'b1;
            fired     = 1'b1;
          end
        end else if (found) begin
          active_d = 1'b1;
          stamp_d  = item_i.now;
        end
      end
    end
  end

  always_comb begin
    out_valid_d = out_valid_q && out_stall_i;
    result_d    = result_q;
    if (take && item_i.last) begin
      out_valid_d      = 1'b1;
      result_d.trigger = fired;
      result_d.total   = total_d;
      result_d.active  = active_d;
      result_d.counted = counted_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q      <= 1'b0;
      active_q    <= 1'b0;
      counted_q   <= 1'b0;
      stamp_q     <= '0;
      total_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      seen_q      <= seen_d;
      active_q    <= active_d;
      counted_q   <= counted_d;
      stamp_q     <= stamp_d;
      total_q     <= total_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    result_q <= result_d;
  end

  assign out_valid_o = out_valid_q;
  assign result_o    = result_q;

endmodule

FILE: hdl/zone_dwell_trigger_core.sv
// channel  dir  handshake                 payload
// in       in   in_valid_i / in_stall_o   point_x_i point_y_i point_valid_i frame_end_i now_ms_i
// out      out  out_valid_o / out_stall_i trigger_o trigger_total_o zone_active_o zone_counted_o
// cfg      in   cfg_we_i                  cfg_idx_i cfg_wdata_i
//
// one transfer per cycle while in_stall_o is low; a frame-end result goes through stage one
// to the result register; stage one registers the zone test of the point, stage two
// updates zone state and the result register
// reset clears all zone state, the trigger count and the configuration registers
// out_stall_i only holds frame-end items; plain points pass until one of those stalls the input
module zone_dwell_trigger_core (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // configuration
  input  logic                                cfg_we_i,
  input  logic [zdt_pkg::CFG_IDX_BITS-1:0]    cfg_idx_i,
  input  logic [zdt_pkg::CFG_DATA_BITS-1:0]   cfg_wdata_i,
  // input channel
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [zdt_pkg::COORD_BITS-1:0]      point_x_i,
  input  logic [zdt_pkg::COORD_BITS-1:0]      point_y_i,
  input  logic                                point_valid_i,
  input  logic                                frame_end_i,
  input  logic [zdt_pkg::TIME_BITS-1:0]       now_ms_i,
  // result channel
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic                                trigger_o,
  output logic [zdt_pkg::TOTAL_BITS-1:0]      trigger_total_o,
  output logic                                zone_active_o,
  output logic                                zone_counted_o
);
  import zdt_pkg::*;

  cfg_t    cfg;
  logic    hit;
  logic    in_take;
  logic    zone_ready;
  result_t result;

  // stage one holds the zone test result of the point, its frame mark and timestamp
  logic  s1_valid_q, s1_valid_d;
  item_t s1_item_q;

  zdt_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  // strict inside test on the incoming point
  zdt_hit u_hit (
    .cfg_i         (cfg),
    .point_x_i     (point_x_i),
    .point_y_i     (point_y_i),
    .point_valid_i (point_valid_i),
    .hit_o         (hit)
  );

  // stage one stalls only when its item closes a frame and the result register is full
  assign in_stall_o = s1_valid_q && !zone_ready;
  assign in_take    = in_valid_i && !in_stall_o;

  always_comb begin
    s1_valid_d = s1_valid_q && !zone_ready;
    if (in_take) begin
      s1_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      s1_item_q.hit  <= hit;
      s1_item_q.last <= frame_end_i;
      s1_item_q.now  <= now_ms_i;
    end
  end

  // zone state update and result register
  zdt_zone u_zone (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .item_valid_i (s1_valid_q),
    .item_i       (s1_item_q),
    .item_ready_o (zone_ready),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .result_o     (result)
  );

  assign trigger_o       = result.trigger;
  assign trigger_total_o = result.total;
  assign zone_active_o   = result.active;
  assign zone_counted_o  = result.counted;

endmodule

FILE: tb/zdt_tb_pkg.sv
`timescale 1ns / 100ps

package zdt_tb_pkg;
  import zdt_pkg::*;

  class zone_dwell_scoreboard;
    // zone registers as last written
    logic [COORD_BITS-1:0] left_q, top_q, width_q, height_q;
    logic [TIME_BITS-1:0]  dwell_q;
    // zone state after the last noted transfer
    bit                    seen_hit;
    bit                    active;
    bit                    counted;
    logic [TIME_BITS-1:0]  stamp;
    logic [TOTAL_BITS-1:0] total;

    result_t pending_frames[$];
    int transfers;
    int useful_transfers;
    int frames_checked;
    int triggers_seen;
    int mismatches;

    function new();
      left_q = '0;
      top_q = '0;
      width_q = '0;
      height_q = '0;
      dwell_q = '0;
      seen_hit = 1'b0;
      active = 1'b0;
      counted = 1'b0;
      stamp = '0;
      total = '0;
      transfers = 0;
      useful_transfers = 0;
      frames_checked = 0;
      triggers_seen = 0;
      mismatches = 0;
    endfunction

    function void write_register(logic [CFG_IDX_BITS-1:0] idx,
                                 logic [CFG_DATA_BITS-1:0] data);
      case (idx)
        CFG_ZONE_LEFT:   left_q = data[COORD_BITS-1:0];
        CFG_ZONE_TOP:    top_q = data[COORD_BITS-1:0];
        CFG_ZONE_WIDTH:  width_q = data[COORD_BITS-1:0];
        CFG_ZONE_HEIGHT: height_q = data[COORD_BITS-1:0];
        CFG_DWELL_LIMIT: dwell_q = data[TIME_BITS-1:0];
        default: ;
      endcase
    endfunction

    // one accepted input transfer; a frame end closes the frame and predicts its result
    function void note_transfer(logic [COORD_BITS-1:0] x, logic [COORD_BITS-1:0] y,
                                logic pv, logic fe, logic [TIME_BITS-1:0] now);
      logic [COORD_BITS:0]  right_bound, bottom_bound;
      logic [TIME_BITS-1:0] elapsed;
      bit                   found;
      result_t              want;
      transfers++;
      if (pv || fe) useful_transfers++;
      // bounds one bit wider so nothing wraps
      right_bound = {1'b0, left_q} + {1'b0, width_q};
      bottom_bound = {1'b0, top_q} + {1'b0, height_q};
      if (pv && x > left_q && {1'b0, x} < right_bound && y > top_q && {1'b0, y} < bottom_bound)
        seen_hit = 1'b1;
      if (!fe) return;
      found = seen_hit;
      seen_hit = 1'b0;
      want.trigger = 1'b0;
      if (active) begin
        if (!found) begin
          active = 1'b0;
          counted = 1'b0;
          stamp = '0;
        end else if (!counted) begin
          elapsed = now - stamp;
          if (elapsed > dwell_q) begin
            total = total + TOTAL_BITS'(1);
            counted = 1'b1;
            want.trigger = 1'b1;
          end
        end
      end else if (found) begin
        active = 1'b1;
        stamp = now;
      end
      want.total = total;
      want.active = active;
      want.counted = counted;
      pending_frames.push_back(want);
    endfunction

    function void compare_field(string field, logic [TOTAL_BITS-1:0] want,
                                logic [TOTAL_BITS-1:0] got);
      if (want !== got) begin
        mismatches++;
        if (mismatches <= 10)
          $display("[%0t] frame %0d: %s expected %0d, got %0d",
                   $time, frames_checked, field, want, got);
      end
    endfunction

    function void check_frame_result(result_t got);
      result_t want;
      if (pending_frames.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display({"[%0t] result with no frame pending: ",
                    "trigger %0b total %0d active %0b counted %0b"},
                   $time, got.trigger, got.total, got.active, got.counted);
        return;
      end
      want = pending_frames.pop_front();
      compare_field("trigger", TOTAL_BITS'(want.trigger), TOTAL_BITS'(got.trigger));
      compare_field("trigger_total", want.total, got.total);
      compare_field("zone_active", TOTAL_BITS'(want.active), TOTAL_BITS'(got.active));
      compare_field("zone_counted", TOTAL_BITS'(want.counted), TOTAL_BITS'(got.counted));
      if (got.trigger === 1'b1) triggers_seen++;
      frames_checked++;
    endfunction
  endclass

endpackage

FILE: tb/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
  import zdt_pkg::*;
  import zdt_tb_pkg::*;

  localparam int COORD_MAX = (1 << COORD_BITS) - 1;
  localparam int ZONE_SETTINGS = 9;
  localparam int ITEMS_PER_SETTING = 205;
  localparam int DRAIN_LIMIT = 5000;
  localparam int PRESSURE_HOLD = 400;

  logic                     clk_i;
  logic                     rst_ni;
  logic                     cfg_we_i;
  logic [CFG_IDX_BITS-1:0]  cfg_idx_i;
  logic [CFG_DATA_BITS-1:0] cfg_wdata_i;
  logic                     in_valid_i;
  logic                     in_stall_o;
  logic [COORD_BITS-1:0]    point_x_i;
  logic [COORD_BITS-1:0]    point_y_i;
  logic                     point_valid_i;
  logic                     frame_end_i;
  logic [TIME_BITS-1:0]     now_ms_i;
  logic                     out_valid_o;
  logic                     out_stall_i;
  logic                     trigger_o;
  logic [TOTAL_BITS-1:0]    trigger_total_o;
  logic                     zone_active_o;
  logic                     zone_counted_o;

  zone_dwell_scoreboard sb;
  int burst_left;     // sender transfers still to go back to back
  bit pressure_done;  // long output hold-off has happened

  zone_dwell_trigger_core DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .point_x_i       (point_x_i),
    .point_y_i       (point_y_i),
    .point_valid_i   (point_valid_i),
    .frame_end_i     (frame_end_i),
    .now_ms_i        (now_ms_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .trigger_o       (trigger_o),
    .trigger_total_o (trigger_total_o),
    .zone_active_o   (zone_active_o),
    .zone_counted_o  (zone_counted_o)
  );

  // 4 ns clock
  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // run limit, well past the slowest legal run
  initial begin
    #4_000_000;
    $display("FAILURE");
    $finish;
  end

  // input side: every accepted transfer goes to the predictor
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && !in_stall_o)
      sb.note_transfer(point_x_i, point_y_i, point_valid_i, frame_end_i, now_ms_i);
  end

  // result side: every accepted transfer is checked against the oldest prediction
  always @(posedge clk_i) begin : result_monitor
    result_t seen;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      seen.trigger = trigger_o;
      seen.total = trigger_total_o;
      seen.active = zone_active_o;
      seen.counted = zone_counted_o;
      sb.check_frame_result(seen);
    end
  end

  // receiver: runs of acceptance and hold-offs of random length, one long hold-off
  // once results are flowing so the block backs up into its input
  initial begin : result_stall
    int run_len;
    int hold_len;
    int r;
    out_stall_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      run_len = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 200) : $urandom_range(1, 8);
      r = $urandom_range(0, 99);
      if (!pressure_done && sb.frames_checked >= 60) begin
        hold_len = PRESSURE_HOLD;
        pressure_done = 1'b1;
      end else if (r < 35) begin
        hold_len = 0;
      end else if (r < 85) begin
        hold_len = $urandom_range(1, 3);
      end else if (r < 97) begin
        hold_len = $urandom_range(4, 12);
      end else begin
        hold_len = $urandom_range(20, 60);
      end
      @(negedge clk_i);
      out_stall_i <= 1'b0;
      repeat (run_len - 1) @(negedge clk_i);
      if (hold_len > 0) begin
        @(negedge clk_i);
        out_stall_i <= 1'b1;
        repeat (hold_len - 1) @(negedge clk_i);
      end
    end
  end

  // sender gap: mostly none or short, a few long, now and then a long burst
  function automatic int pick_sender_gap();
    int r;
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) begin
      burst_left = $urandom_range(30, 150);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // offer one item and hold it until the block takes it
  task automatic send_item(input logic [COORD_BITS-1:0] x, input logic [COORD_BITS-1:0] y,
                           input logic pv, input logic fe, input logic [TIME_BITS-1:0] now);
    int gap;
    gap = pick_sender_gap();
    if (gap > 0) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    point_x_i <= x;
    point_y_i <= y;
    point_valid_i <= pv;
    frame_end_i <= fe;
    now_ms_i <= now;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                           input logic [CFG_DATA_BITS-1:0] data);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= data;
    sb.write_register(idx, data);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // stop offering, wait for every predicted result, then let the two-stage pipe empty
  task automatic drain_pipeline();
    int waited;
    waited = 0;
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (sb.pending_frames.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_zone(input int left, input int top, input int width, input int height,
                          input logic [TIME_BITS-1:0] dwell);
    write_reg(CFG_ZONE_LEFT, left);
    write_reg(CFG_ZONE_TOP, top);
    write_reg(CFG_ZONE_WIDTH, width);
    write_reg(CFG_ZONE_HEIGHT, height);
    write_reg(CFG_DWELL_LIMIT, dwell);
  endtask

  // a point strictly within the zone when asked and possible, else a rim
  // point or anywhere at all
  function automatic void pick_point(input bit want_hit, output logic [COORD_BITS-1:0] x,
                                     output logic [COORD_BITS-1:0] y);
    int lo_x, hi_x, lo_y, hi_y;
    lo_x = int'(sb.left_q) + 1;
    hi_x = int'(sb.left_q) + int'(sb.width_q) - 1;
    lo_y = int'(sb.top_q) + 1;
    hi_y = int'(sb.top_q) + int'(sb.height_q) - 1;
    if (hi_x > COORD_MAX) hi_x = COORD_MAX;
    if (hi_y > COORD_MAX) hi_y = COORD_MAX;
    if (want_hit && lo_x <= hi_x && lo_y <= hi_y) begin
      x = COORD_BITS'($urandom_range(hi_x, lo_x));
      y = COORD_BITS'($urandom_range(hi_y, lo_y));
    end else if ($urandom_range(0, 1) == 0) begin
      x = COORD_BITS'($urandom);
      y = COORD_BITS'($urandom);
    end else begin
      x = COORD_BITS'((lo_x <= hi_x) ? $urandom_range(hi_x, lo_x) : $urandom);
      y = COORD_BITS'((lo_y <= hi_y) ? $urandom_range(hi_y, lo_y) : $urandom);
      // exactly on one of the exclusive bounds
      case ($urandom_range(0, 3))
        0: x = sb.left_q;
        1: x = sb.left_q + sb.width_q;
        2: y = sb.top_q;
        default: y = sb.top_q + sb.height_q;
      endcase
    end
  endfunction

  // one well-formed frame: a few hull points then the frame end; a present
  // frame puts one point in the zone, possibly on the frame end itself
  task automatic send_frame(input bit present, input logic [TIME_BITS-1:0] frame_ms);
    int n_pts;
    int hit_at;
    logic [COORD_BITS-1:0] x, y;
    logic pv;
    n_pts = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 16) : $urandom_range(0, 3);
    hit_at = present ? $urandom_range(0, n_pts) : -1;
    for (int i = 0; i <= n_pts; i++) begin
      // stray empty transfer inside the frame
      if (i < n_pts && $urandom_range(0, 15) == 0)
        send_item(COORD_BITS'($urandom), COORD_BITS'($urandom), 1'b0, 1'b0, $urandom);
      pick_point(i == hit_at, x, y);
      pv = 1'b1;
      if (i == n_pts && i != hit_at && $urandom_range(0, 1) == 0) pv = 1'b0;
      send_item(x, y, pv, i == n_pts, frame_ms);
    end
  endtask

  task automatic configure_setting(input int idx, output int step_max,
                                   output logic [TIME_BITS-1:0] start_ms);
    start_ms = $urandom;
    step_max = 40;
    case (idx)
      // whole coordinate range, count on the first frame after activation
      0: set_zone(0, 0, COORD_MAX, COORD_MAX, '0);
      // rectangle starting at the top corner and running past the range
      1: set_zone(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, '1);
      // zero width
      2: set_zone(2000, 1000, 0, 300, 100);
      // ordinary zone, clock about to wrap
      3: begin
        set_zone($urandom_range(0, 3000), $urandom_range(0, 3000), $urandom_range(2, 600),
                 $urandom_range(2, 600), $urandom_range(0, 400));
        start_ms = 32'hFFFF_F000;
      end
      // largest dwell, never counts
      4: set_zone($urandom_range(0, 3000), $urandom_range(0, 3000), $urandom_range(2, 900),
                  $urandom_range(2, 900), '1);
      // partly past the range, zero height in the last setting
      5: set_zone(3000, 3500, COORD_MAX, 2000, 200);
      // dwell anywhere in the time range, clock jumps decide
      6: begin
        set_zone($urandom_range(0, 3000), $urandom_range(0, 3000), $urandom_range(2, 900),
                 $urandom_range(2, 900), $urandom);
        step_max = 2000;
      end
      // single interior pixel
      7: set_zone($urandom_range(0, 4093), $urandom_range(0, 4093), 2, 2, '0);
      // zero height
      default: set_zone($urandom_range(0, 3000), $urandom_range(0, 3000),
                        $urandom_range(2, 900), 0, 60);
    endcase
  endtask

  initial begin : stimulus
    logic [TIME_BITS-1:0] clock_ms;
    int step_max;
    int target;
    int r;
    bit present;
    sb = new();
    burst_left = 0;
    pressure_done = 1'b0;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = '0;
    cfg_wdata_i = '0;
    in_valid_i = 1'b0;
    point_x_i = '0;
    point_y_i = '0;
    point_valid_i = 1'b0;
    frame_end_i = 1'b0;
    now_ms_i = '0;
    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;

    // reset zone is empty: nothing can be inside
    send_item(1, 1, 1'b1, 1'b1, 123);
    drain_pipeline();

    // directed: zone x 101..149, y 201..239, dwell 10 ms
    set_zone(100, 200, 50, 40, 10);
    send_item(0, 0, 1'b0, 1'b0, 0);                    // empty transfer
    send_item(0, 0, 1'b0, 1'b1, 0);                    // empty frame end
    send_item(100, 220, 1'b1, 1'b0, 0);                // left bound
    send_item(150, 220, 1'b1, 1'b0, 0);                // right bound
    send_item(120, 200, 1'b1, 1'b0, 0);                // top bound
    send_item(120, 240, 1'b1, 1'b0, 0);                // bottom bound
    send_item(120, 220, 1'b0, 1'b1, 500);              // inside but not a point
    send_item(101, 201, 1'b1, 1'b1, 1000);             // point on frame end activates
    send_item(149, 239, 1'b1, 1'b1, 1005);             // 5 ms, still waiting
    send_item(4095, 4095, 1'b1, 1'b0, 1005);           // far corner
    send_item(130, 210, 1'b1, 1'b0, 1010);
    send_item(0, 0, 1'b0, 1'b1, 1010);                 // exactly the dwell, no count
    send_item(130, 210, 1'b1, 1'b1, 1011);             // dwell exceeded, trigger
    send_item(130, 210, 1'b1, 1'b1, 2000);             // already counted
    send_item(0, 0, 1'b1, 1'b1, 2001);                 // zone empties
    send_item(125, 225, 1'b1, 1'b1, 32'hFFFF_FFF0);    // activate just before wrap
    send_item(125, 225, 1'b1, 1'b1, 32'h0000_0005);    // elapsed wraps, trigger
    send_item(4095, 0, 1'b1, 1'b1, 32'hFFFF_FFFF);     // empties again
    drain_pipeline();

    // random: presence runs of well-formed frames with a share of noise
    for (int s = 0; s < ZONE_SETTINGS; s++) begin
      configure_setting(s, step_max, clock_ms);
      target = sb.useful_transfers + ITEMS_PER_SETTING;
      present = 1'b0;
      while (sb.useful_transfers < target) begin
        r = $urandom_range(0, 19);
        if (r == 0) begin
          // unstructured transfer, may cut a frame short
          send_item(COORD_BITS'($urandom), COORD_BITS'($urandom),
                    1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), $urandom);
        end else if (r == 1) begin
          clock_ms = $urandom;
        end else begin
          if ($urandom_range(0, 11) == 0) present = !present;
          clock_ms = clock_ms + $urandom_range(0, step_max);
          send_frame(present, clock_ms);
        end
      end
      drain_pipeline();
    end

    if (sb.pending_frames.size() != 0)
      $display("%0d predicted frame results never arrived", sb.pending_frames.size());
    $display("run covered %0d input transfers and %0d frame results over %0d zone settings",
             sb.transfers, sb.frames_checked, ZONE_SETTINGS + 2);
    $display("trigger pulses seen: %0d, long output hold-off applied: %0b",
             sb.triggers_seen, pressure_done);
    if (sb.mismatches == 0 && sb.pending_frames.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
